FILE: sv/ppu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants of the polygon perimeter unit.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int unsigned SUM_W      = 32;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SEG,
    ST_CLOSE,
    ST_EMIT
  } ppu_state_t;

  // segment length unit
  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_MUL,
    SEG_SUM,
    SEG_ROOT,
    SEG_DONE
  } seg_state_t;

endpackage

FILE: sv/polygon_perimeter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_perimeter_unit
// Accumulates the perimeter of polygons given vertex by vertex.
// ----------------------------------------------------------------------------
// Vertices arrive one per item as signed fixed-point x and y with 4 fraction
// bits; tlast marks the final vertex, after which the closing segment back to
// the first vertex is added and one result (perimeter with 4 fraction bits,
// vertex count, both saturating) leaves on the out channel. Each segment
// length is found by a bit-serial squarer and a bit-pair square root, which
// take the length unit through its multiply, sum, root and done states. An
// item is accepted, launches the segment from the previous vertex and waits
// for its length; the first vertex of a polygon launches none, and a final
// vertex also launches the closing segment and then writes the result.
// One item is in work at a time; a waiting result does not stop new items
// until the next result is ready to be written.
module polygon_perimeter_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [COORD_BITS-1:0] x, [2*COORD_BITS-1:COORD_BITS] y, zero padded to bytes
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] perimeter, [47:32] vertex_count
  output logic [ppu_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ppu_pkg::*;

  localparam int unsigned W  = COORD_BITS + 1;
  localparam int unsigned EW = ((W > SUM_W) ? W : SUM_W) + 1;

  ppu_state_t state_r, state_nxt;

  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r;
  logic                         last_r;
  logic                         have_first_r;
  logic [SUM_W-1:0]             sum_r;
  logic [CNT_W-1:0]             count_r;
  logic                         out_tvalid_r;
  logic [OUT_DATA_W-1:0]        out_tdata_r;

  logic                         accept;
  logic                         emit;
  logic                         seg_start;
  logic                         seg_done;
  logic [W-1:0]                 seg_len;
  logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y;
  logic [EW-1:0]                sum_wide;
  logic [SUM_W-1:0]             sum_sat;

  ppu_seg_len #(
    .COORD_BITS(COORD_BITS)
  ) u_seg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seg_start),
    .a_x   (a_x),
    .a_y   (a_y),
    .b_x   (b_x),
    .b_y   (b_y),
    .done  (seg_done),
    .len   (seg_len)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_START;
      ST_START: begin
        if (have_first_r) state_nxt = ST_SEG;
        else if (last_r)  state_nxt = ST_EMIT;
        else              state_nxt = ST_IDLE;
      end
      ST_SEG:   if (seg_done) state_nxt = last_r ? ST_CLOSE : ST_IDLE;
      ST_CLOSE: if (seg_done) state_nxt = ST_EMIT;
      ST_EMIT:  if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    accept    = in_tvalid && in_tready;
    emit      = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
    // closing segment launches as the last open segment completes
    seg_start = ((state_r == ST_START) && have_first_r) ||
                ((state_r == ST_SEG) && seg_done && last_r);
    if (state_r == ST_SEG) begin
      a_x = cur_x_r;
      a_y = cur_y_r;
      b_x = first_x_r;
      b_y = first_y_r;
    end else begin
      a_x = prev_x_r;
      a_y = prev_y_r;
      b_x = cur_x_r;
      b_y = cur_y_r;
    end
    sum_wide = EW'(sum_r) + EW'(seg_len);
    sum_sat  = (sum_wide[EW-1:SUM_W] != '0) ? SUM_MAX : sum_wide[SUM_W-1:0];
    out_tvalid = out_tvalid_r;
    out_tdata  = out_tdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      have_first_r <= 1'b0;
      sum_r        <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        have_first_r <= 1'b0;
        sum_r        <= '0;
        count_r      <= '0;
      end else begin
        if (accept && count_r != CNT_MAX) count_r <= count_r + 1'b1;
        if (state_r == ST_START) have_first_r <= 1'b1;
        if ((state_r == ST_SEG || state_r == ST_CLOSE) && seg_done) sum_r <= sum_sat;
      end
      if (emit) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x_r <= in_tdata[COORD_BITS-1:0];
      cur_y_r <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      last_r  <= in_tlast;
    end
    if (state_r == ST_START && !have_first_r) begin
      first_x_r <= cur_x_r;
      first_y_r <= cur_y_r;
      prev_x_r  <= cur_x_r;
      prev_y_r  <= cur_y_r;
    end else if (state_r == ST_SEG && seg_done) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
    end
    if (emit) out_tdata_r <= {count_r, sum_r};
  end

endmodule

FILE: sv/ppu_seg_len.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_seg_len
// Length of one segment: floor(sqrt(dx*dx + dy*dy)). Both squares come from
// bit-serial shift-add multipliers, the root from a restoring bit-pair loop.
// ----------------------------------------------------------------------------
module ppu_seg_len #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  output logic                         done,
  output logic [COORD_BITS:0]          len
);
  import ppu_pkg::*;

  localparam int unsigned W    = COORD_BITS + 1;
  localparam int unsigned CNTW = $clog2(W);
  localparam logic [CNTW-1:0] LAST_STEP = CNTW'(W - 1);

  seg_state_t state_r, state_nxt;

  logic [CNTW-1:0] cnt_r;
  logic [W-1:0]    mc_x_r, mc_y_r;
  logic [2*W-1:0]  px_r, py_r;
  logic [2*W-1:0]  sq_r;
  logic [W:0]      rem_r;
  logic [W-1:0]    root_r;

  logic signed [COORD_BITS:0] dxs, dys;
  logic [W-1:0]    dx, dy;
  logic [W:0]      acc_x, acc_y;
  logic [W+2:0]    rem_sh, trial, rem_sub;
  logic            take;
  logic            load;

  // signed differences and their magnitudes
  always_comb begin
    dxs = {b_x[COORD_BITS-1], b_x} - {a_x[COORD_BITS-1], a_x};
    dys = {b_y[COORD_BITS-1], b_y} - {a_y[COORD_BITS-1], a_y};
    dx  = dxs[COORD_BITS] ? W'(-dxs) : W'(dxs);
    dy  = dys[COORD_BITS] ? W'(-dys) : W'(dys);
  end

  // one multiplier bit and one root bit pair per cycle
  always_comb begin
    acc_x   = {1'b0, px_r[2*W-1:W]} + (px_r[0] ? {1'b0, mc_x_r} : '0);
    acc_y   = {1'b0, py_r[2*W-1:W]} + (py_r[0] ? {1'b0, mc_y_r} : '0);
    rem_sh  = {rem_r, sq_r[2*W-1:2*W-2]};
    trial   = {1'b0, root_r, 2'b01};
    take    = rem_sh >= trial;
    rem_sub = rem_sh - trial;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEG_IDLE: if (start) state_nxt = SEG_MUL;
      SEG_MUL:  if (cnt_r == '0) state_nxt = SEG_SUM;
      SEG_SUM:  state_nxt = SEG_ROOT;
      SEG_ROOT: if (cnt_r == '0) state_nxt = SEG_DONE;
      SEG_DONE: state_nxt = start ? SEG_MUL : SEG_IDLE;
      default:  state_nxt = SEG_IDLE;
    endcase
  end

  always_comb begin
    load = start && (state_r == SEG_IDLE || state_r == SEG_DONE);
    done = (state_r == SEG_DONE);
    len  = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mc_x_r <= dx;
      mc_y_r <= dy;
      px_r   <= {{W{1'b0}}, dx};
      py_r   <= {{W{1'b0}}, dy};
      cnt_r  <= LAST_STEP;
    end else begin
      unique case (state_r)
        SEG_MUL: begin
          px_r  <= {acc_x, px_r[W-1:1]};
          py_r  <= {acc_y, py_r[W-1:1]};
          cnt_r <= cnt_r - 1'b1;
        end
        SEG_SUM: begin
          sq_r   <= px_r + py_r;
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= LAST_STEP;
        end
        SEG_ROOT: begin
          sq_r   <= {sq_r[2*W-3:0], 2'b00};
          rem_r  <= take ? rem_sub[W:0] : rem_sh[W:0];
          root_r <= {root_r[W-2:0], take};
          cnt_r  <= cnt_r - 1'b1;
        end
        SEG_IDLE, SEG_DONE: begin
          cnt_r <= cnt_r;
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

endmodule

FILE: sv/ppu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_checker
// Port-level checks of the polygon perimeter unit, bound to the top level.
// ----------------------------------------------------------------------------
module ppu_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          in_tlast,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ppu_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ppu_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while another is in work");

  // every polygon has at least one vertex
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:SUM_W] != '0)
    else $error("result with zero vertex count");

  // no result rises right after a non-final vertex is accepted
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> !$rose(out_tvalid))
    else $error("result right after a non-final vertex");

endmodule

bind polygon_perimeter_unit ppu_checker u_ppu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/tb_polygon_perimeter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_perimeter_unit
// Self-checking bench for the polygon perimeter unit.
// ----------------------------------------------------------------------------
// A short table of hand-picked polygons (single vertex, two vertices, full
// scale extremes, identical vertices) is walked first, then random polygons
// of random size with small, full range and extreme coordinates. Every
// accepted vertex runs through a local perimeter model; each result leaving
// the unit is compared with the oldest expected one. Both stream sides idle
// at random, except during a calm stretch in the middle of the run.
module tb_polygon_perimeter_unit;
  import ppu_pkg::*;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned IN_DATA_W  = ((2*COORD_BITS+7)/8)*8;
  localparam int unsigned N_TABLE    = 22;
  localparam int unsigned N_RANDOM   = 1430;
  localparam int unsigned STALL_PCT  = 14;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned DRAIN_CYC  = 200;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [SUM_W-1:0] perimeter;
    logic [CNT_W-1:0] vertex_count;
  } polygon_result_t;

  typedef struct packed {
    coord_t          x;
    coord_t          y;
    logic            last;
    logic            known;
    polygon_result_t result;
  } shape_row_t;

  // hand-picked polygons; known rows carry their perimeter and count
  shape_row_t shape_table [N_TABLE] = '{
    // single vertex at the origin and at a corner
    '{16'sd0,      16'sd0,      1'b1, 1'b1, '{32'd0,      16'd1}},
    '{-16'sd32768, 16'sd32767,  1'b1, 1'b1, '{32'd0,      16'd1}},
    // Pythagorean-triple edge out and back
    '{16'sd0,      16'sd0,      1'b0, 1'b0, '{32'd0,      16'd0}},
    '{16'sd48,     16'sd64,     1'b1, 1'b1, '{32'd160,    16'd2}},
    // full scale diagonal
    '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, '{32'd0,      16'd0}},
    '{16'sd32767,  16'sd32767,  1'b1, 1'b1, '{32'd185360, 16'd2}},
    // full scale horizontal
    '{-16'sd32768, 16'sd0,      1'b0, 1'b0, '{32'd0,      16'd0}},
    '{16'sd32767,  16'sd0,      1'b1, 1'b1, '{32'd131070, 16'd2}},
    // right triangle
    '{16'sd0,      16'sd0,      1'b0, 1'b0, '{32'd0,      16'd0}},
    '{16'sd48,     16'sd0,      1'b0, 1'b0, '{32'd0,      16'd0}},
    '{16'sd48,     16'sd64,     1'b1, 1'b1, '{32'd192,    16'd3}},
    // largest square
    '{16'sd32767,  16'sd32767,  1'b0, 1'b0, '{32'd0,      16'd0}},
    '{-16'sd32768, 16'sd32767,  1'b0, 1'b0, '{32'd0,      16'd0}},
    '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, '{32'd0,      16'd0}},
    '{16'sd32767,  -16'sd32768, 1'b1, 1'b1, '{32'd262140, 16'd4}},
    // fractional steps
    '{16'sd5,      -16'sd3,     1'b0, 1'b0, '{32'd0,      16'd0}},
    '{-16'sd7,     16'sd11,     1'b0, 1'b0, '{32'd0,      16'd0}},
    '{16'sd1,      16'sd1,      1'b1, 1'b0, '{32'd0,      16'd0}},
    // identical vertices
    '{16'sd100,    16'sd100,    1'b0, 1'b0, '{32'd0,      16'd0}},
    '{16'sd100,    16'sd100,    1'b1, 1'b1, '{32'd0,      16'd2}},
    // one lsb diagonal rounds down to one
    '{-16'sd1,     -16'sd1,     1'b0, 1'b0, '{32'd0,      16'd0}},
    '{16'sd0,      16'sd0,      1'b1, 1'b1, '{32'd2,      16'd2}}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  polygon_result_t pending_results [$];
  int unsigned     err_count  = 0;
  int unsigned     idle_count = 0;
  bit              calm       = 1'b0;

  // perimeter model state
  coord_t           first_x, first_y, prev_x, prev_y;
  logic [SUM_W-1:0] edge_sum;
  logic [CNT_W-1:0] vert_count;
  logic             have_first;

  polygon_perimeter_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    if (err_count < 40) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  function automatic logic [SUM_W-1:0] edge_length(input coord_t ax, input coord_t ay,
                                                   input coord_t bx, input coord_t by);
    longint        ddx, ddy;
    logic [63:0]   radicand, rem, root, trial;
    ddx = longint'(bx) - longint'(ax);
    ddy = longint'(by) - longint'(ay);
    if (ddx < 0) ddx = -ddx;
    if (ddy < 0) ddy = -ddy;
    radicand = 64'(ddx * ddx) + 64'(ddy * ddy);
    rem  = '0;
    root = '0;
    // bit-pair square root, floor
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((radicand >> (2*i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[SUM_W-1:0];
  endfunction

  function automatic void add_edge(input logic [SUM_W-1:0] len);
    logic [SUM_W:0] total;
    total    = {1'b0, edge_sum} + {1'b0, len};
    edge_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
  endfunction

  function automatic void clear_polygon();
    first_x    = '0;
    first_y    = '0;
    prev_x     = '0;
    prev_y     = '0;
    edge_sum   = '0;
    vert_count = '0;
    have_first = 1'b0;
  endfunction

  // steps the model by one vertex; a final vertex closes the polygon
  function automatic void advance_perimeter(input coord_t vx, input coord_t vy,
                                            input logic vlast, output logic produced,
                                            output polygon_result_t res);
    if (!have_first) begin
      first_x    = vx;
      first_y    = vy;
      have_first = 1'b1;
    end else begin
      add_edge(edge_length(prev_x, prev_y, vx, vy));
    end
    prev_x = vx;
    prev_y = vy;
    if (vert_count != CNT_MAX) vert_count++;
    produced = vlast;
    res      = '0;
    if (vlast) begin
      add_edge(edge_length(vx, vy, first_x, first_y));
      res.perimeter    = edge_sum;
      res.vertex_count = vert_count;
      clear_polygon();
    end
  endfunction

  task automatic send_vertex(input coord_t vx, input coord_t vy, input logic vlast,
                             input logic known, input polygon_result_t typed);
    logic            produced;
    polygon_result_t predicted;
    if (!calm) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {vy, vx};
    in_tlast  <= vlast;
    do @(posedge clk); while (!in_tready);
    advance_perimeter(vx, vy, vlast, produced, predicted);
    if (produced) pending_results.push_back(known ? typed : predicted);
  endtask

  function automatic coord_t pick_coord(input int unsigned mode);
    case (mode)
      0: return coord_t'($urandom_range(400) - 200);
      1: return coord_t'($urandom);
      default: begin
        case ($urandom_range(3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  // result side: random back-pressure
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    polygon_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      // perimeter in the low bits, vertex count above it
      got.perimeter    = out_tdata[SUM_W-1:0];
      got.vertex_count = out_tdata[OUT_DATA_W-1:SUM_W];
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result perimeter=%0d count=%0d",
                                got.perimeter, got.vertex_count));
      end else begin
        want = pending_results.pop_front();
        if (got.perimeter !== want.perimeter)
          flag_mismatch($sformatf("perimeter %0d, expected %0d",
                                  got.perimeter, want.perimeter));
        if (got.vertex_count !== want.vertex_count)
          flag_mismatch($sformatf("vertex_count %0d, expected %0d",
                                  got.vertex_count, want.vertex_count));
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  initial begin
    int unsigned     sent;
    int unsigned     nverts;
    int unsigned     mode;
    polygon_result_t none;
    none = '0;
    clear_polygon();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_TABLE; r++) begin
      send_vertex(shape_table[r].x, shape_table[r].y, shape_table[r].last,
                  shape_table[r].known, shape_table[r].result);
    end

    sent = 0;
    while (sent < N_RANDOM) begin
      // mostly small polygons, now and then a long one
      nverts = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      mode   = $urandom_range(99);
      mode   = (mode < 60) ? 0 : (mode < 85) ? 1 : 2;
      for (int v = 1; v <= nverts; v++) begin
        calm = (sent >= 500) && (sent < 800);
        send_vertex(pick_coord(mode), pick_coord(mode), v == nverts, 1'b0, none);
        sent++;
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: polygon_perimeter_unit.f
sv/ppu_pkg.sv
sv/ppu_seg_len.sv
sv/polygon_perimeter_unit.sv
sv/ppu_checker.sv
test/tb_polygon_perimeter_unit.sv
